### hdl/fra_pkg.sv
// fra_pkg: shared types and constants for the four register alu step
// payload structs, command codes, controller/datapath interface structs
// no dependencies
package fra_pkg;

	localparam int NUM_REGS = 4;
	localparam int XLEN     = 64;
	localparam int IMM_W    = 32;
	localparam int HALF_W   = XLEN / 2;

	// instruction codes
	localparam logic [2:0] OP_INP = 3'd0;
	localparam logic [2:0] OP_ADD = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_MOD = 3'd4;
	localparam logic [2:0] OP_EQL = 3'd5;
	localparam logic [2:0] OP_CLR = 3'd6;

	// register indexes
	localparam logic [1:0] REG_W = 2'd0;
	localparam logic [1:0] REG_X = 2'd1;
	localparam logic [1:0] REG_Y = 2'd2;
	localparam logic [1:0] REG_Z = 2'd3;

	typedef struct packed {
		logic [2:0]               cmd;
		logic [1:0]               dest_reg;
		logic                     src_is_reg;
		logic [1:0]               src_reg;
		logic signed [IMM_W-1:0]  immediate;
		logic signed [XLEN-1:0]   input_value;
	} item_t;

	typedef struct packed {
		logic signed [XLEN-1:0] reg_w;
		logic signed [XLEN-1:0] reg_x;
		logic signed [XLEN-1:0] reg_y;
		logic signed [XLEN-1:0] reg_z;
		logic                   faulted;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] mul_phase;
		logic       div_step;
		logic       commit;
	} dp_cmd_t;

	// datapath to controller, decoded from the incoming item
	typedef struct packed {
		logic item_mul;
		logic item_div;
	} dp_status_t;

endpackage

### hdl/fra_ctrl.sv
// fra_ctrl: sequencing state machine for the four register alu step
// depends on fra_pkg
module fra_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	output logic                 result_valid,
	input  logic                 result_stall,
	input  fra_pkg::dp_status_t  status,
	output fra_pkg::dp_cmd_t     cmd
);
	import fra_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [5:0] CNT_ZERO     = 6'd0;
	localparam logic [5:0] CNT_ONE      = 6'd1;
	localparam logic [5:0] DIV_LAST     = 6'(XLEN - 1);
	localparam logic [5:0] MUL_LAST     = 6'd3;

	logic [1:0] state_q;
	logic [5:0] cnt_q;
	logic       valid_q;
	logic       accept;
	logic       out_free;
	logic       commit;

	assign accept   = item_valid && (state_q == ST_IDLE);
	assign out_free = !valid_q || !result_stall;
	assign commit   = (state_q == ST_DONE) && out_free;

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = valid_q;

	always_comb begin
		cmd.load      = accept;
		cmd.mul_en    = (state_q == ST_MUL);
		cmd.mul_phase = cnt_q[1:0];
		cmd.div_step  = (state_q == ST_DIV);
		cmd.commit    = commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= CNT_ZERO;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (status.item_mul) begin
							state_q <= ST_MUL;
							cnt_q   <= CNT_ZERO;
						end else if (status.item_div) begin
							state_q <= ST_DIV;
							cnt_q   <= DIV_LAST;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + CNT_ONE;
					if (cnt_q == MUL_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - CNT_ONE;
					if (cnt_q == CNT_ZERO) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (commit) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/fra_dp.sv
// fra_dp: register file, operand latches, shared 32x32 multiplier and
// radix-2 restoring divider for the four register alu step; depends on fra_pkg
module fra_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fra_pkg::item_t       item,
	input  fra_pkg::dp_cmd_t     cmd,
	output fra_pkg::dp_status_t  status,
	output fra_pkg::result_t     result
);
	import fra_pkg::*;

	// architectural state
	logic [XLEN-1:0] regs_q [NUM_REGS];
	logic            fault_q;

	// latched instruction
	logic [2:0]      op_q;
	logic [1:0]      dest_q;
	logic [XLEN-1:0] input_q;
	logic [XLEN-1:0] a_q;
	logic [XLEN-1:0] b_q;

	// multiply and divide working registers
	logic [XLEN-1:0] prod_q;
	logic [XLEN-1:0] acc_q;
	logic [XLEN-1:0] quo_q;
	logic [XLEN-1:0] rem_q;
	logic [XLEN-1:0] bmag_q;

	logic [XLEN-1:0] a_sel;
	logic [XLEN-1:0] b_sel;
	logic [HALF_W-1:0] mul_x;
	logic [HALF_W-1:0] mul_y;
	logic [XLEN-1:0] prod;
	logic [XLEN:0]   rem_sh;
	logic [XLEN:0]   diff;

	logic            wr_en;
	logic            clr;
	logic            new_fault;
	logic [XLEN-1:0] wr_val;
	logic [XLEN-1:0] nxt [NUM_REGS];

	// operand fetch straight from the item at accept
	assign a_sel = regs_q[item.dest_reg];
	assign b_sel = item.src_is_reg ? regs_q[item.src_reg]
	                               : {{(XLEN-IMM_W){item.immediate[IMM_W-1]}}, item.immediate};

	always_comb begin
		status.item_mul = (item.cmd == OP_MUL) && !fault_q;
		status.item_div = ((item.cmd == OP_DIV) || (item.cmd == OP_MOD)) && !fault_q;
	end

	// one 32x32 partial product per cycle, low 64 bits of the full product
	assign mul_x = (cmd.mul_phase == 2'd2) ? a_q[XLEN-1:HALF_W] : a_q[HALF_W-1:0];
	assign mul_y = (cmd.mul_phase == 2'd1) ? b_q[XLEN-1:HALF_W] : b_q[HALF_W-1:0];
	assign prod  = XLEN'(mul_x) * XLEN'(mul_y);

	// restoring divide on magnitudes, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[XLEN-1]};
	assign diff   = rem_sh - {1'b0, bmag_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= item.cmd;
			dest_q  <= item.dest_reg;
			input_q <= item.input_value;
			a_q     <= a_sel;
			b_q     <= b_sel;
			quo_q   <= a_sel[XLEN-1] ? (XLEN'(0) - a_sel) : a_sel;
			bmag_q  <= b_sel[XLEN-1] ? (XLEN'(0) - b_sel) : b_sel;
			rem_q   <= '0;
		end else if (cmd.div_step) begin
			if (!diff[XLEN]) begin
				rem_q <= diff[XLEN-1:0];
				quo_q <= {quo_q[XLEN-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[XLEN-1:0];
				quo_q <= {quo_q[XLEN-2:0], 1'b0};
			end
		end

		if (cmd.mul_en) begin
			prod_q <= prod;
			case (cmd.mul_phase)
				2'd0:    acc_q <= acc_q;
				2'd1:    acc_q <= prod_q;
				default: acc_q <= acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
			endcase
		end
	end

	// writeback decision
	always_comb begin
		wr_en     = 1'b0;
		clr       = 1'b0;
		new_fault = fault_q;
		wr_val    = '0;
		if (op_q == OP_CLR) begin
			clr       = 1'b1;
			new_fault = 1'b0;
		end else if (!fault_q) begin
			case (op_q)
				OP_INP: begin
					wr_en  = 1'b1;
					wr_val = input_q;
				end
				OP_ADD: begin
					wr_en  = 1'b1;
					wr_val = a_q + b_q;
				end
				OP_MUL: begin
					wr_en  = 1'b1;
					wr_val = acc_q;
				end
				OP_DIV: begin
					if (b_q == '0) begin
						new_fault = 1'b1;
					end else begin
						wr_en  = 1'b1;
						wr_val = (a_q[XLEN-1] ^ b_q[XLEN-1]) ? (XLEN'(0) - quo_q) : quo_q;
					end
				end
				OP_MOD: begin
					if (a_q[XLEN-1] || b_q[XLEN-1] || (b_q == '0)) begin
						new_fault = 1'b1;
					end else begin
						wr_en  = 1'b1;
						wr_val = rem_q;
					end
				end
				OP_EQL: begin
					wr_en  = 1'b1;
					wr_val = (a_q == b_q) ? XLEN'(1) : XLEN'(0);
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			if (clr) begin
				nxt[i] = '0;
			end else if (wr_en && (dest_q == 2'(i))) begin
				nxt[i] = wr_val;
			end else begin
				nxt[i] = regs_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
			fault_q <= 1'b0;
		end else if (cmd.commit) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= nxt[i];
			end
			fault_q <= new_fault;
		end
	end

	// result register, loaded together with the register file
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result.reg_w   <= nxt[REG_W];
			result.reg_x   <= nxt[REG_X];
			result.reg_y   <= nxt[REG_Y];
			result.reg_z   <= nxt[REG_Z];
			result.faulted <= new_fault;
		end
	end

endmodule

### hdl/four_register_alu_step.sv
// four_register_alu_step: top level of the four register alu step
// depends on fra_pkg, fra_ctrl, fra_dp
//
// Executes one instruction per transfer on four signed 64-bit registers
// w, x, y, z with a sticky fault flag, and answers every instruction with
// one result transfer carrying all four registers and the fault flag as they
// stand afterwards. The block works on one instruction at a time. inp, add,
// eql, clear, an unused code, and anything issued while faulted go straight
// from the accepted transfer to the commit; mul first builds the 64-bit
// product from three partial products through one shared 32x32
// multiplier; div and mod first step through the restoring divider, which
// produces one quotient bit per cycle. The next item is taken in the cycle
// after a result is loaded into the output register, even while that result
// still waits for the receiver, so back-pressure only costs throughput once
// a second result is ready. Divide by zero, and mod with a negative dividend
// or a non-positive divisor, set the fault flag and leave the registers
// untouched; only clear or a reset releases a fault.
module four_register_alu_step (
	input  logic              clk,
	input  logic              arst_n,
	// instruction channel
	input  logic              item_valid,
	output logic              item_stall,
	input  fra_pkg::item_t    item,
	// result channel
	output logic              result_valid,
	input  logic              result_stall,
	output fra_pkg::result_t  result
);
	import fra_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	// sequencer: accepts a transfer, steps the multiply or divide, then
	// commits once the output register is free
	fra_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (dp_status),
		.cmd          (dp_cmd)
	);

	// datapath: register file, operand latches, arithmetic units and the
	// output register
	fra_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (dp_cmd),
		.status (dp_status),
		.result (result)
	);

endmodule
